>>> rtl/edt_pkg.sv
// Shared constants and types for the Euclidean distance table.
// No dependencies; used by euclidean_distance_table.
`default_nettype none

package edt_pkg;

  localparam int POINTS     = 64;
  localparam int IDX_W      = 6;
  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int SUM_W      = 2 * MAG_W + 2;
  localparam int DIST_W     = SUM_W / 2;
  localparam int REM_W      = DIST_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int CNT_W      = $clog2(ROOT_STEPS);
  localparam int POINT_W    = 2 * COORD_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ_A = 7'b0000010,
    S_READ_B = 7'b0000100,
    S_DIFF   = 7'b0001000,
    S_SQ_X   = 7'b0010000,
    S_SQ_Y   = 7'b0100000,
    S_ROOT   = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/euclidean_distance_table.sv
// Euclidean distance table: point store, shared squarer and bit-serial root.
// Depends on edt_pkg and edt_ram.
//
// Usage:
//   The item channel (item_valid/item_ready) carries one beat per item. A beat
//   with op = load writes coord_x/coord_y into slot point_index and gives no
//   result; a load leaves item_ready high, so loads may follow back to back. A beat
//   with op = query reads slots from_index and to_index and gives one result
//   beat on the result channel (result_valid/result_ready) with the floor of
//   the Euclidean distance, as an unsigned integer with no fraction bits.
//   A query reads the point RAM twice, forms the differences, makes two passes
//   through the shared 16x16 squarer and runs 17 iterations of the radix-2
//   square root, one result bit per cycle, then loads the output register.
//   item_ready is low during that time, so a new item is not taken until the
//   query is through. A query with equal indices goes straight to the output
//   register and gives 0.
//   The result sits in an output register; item_ready returns while it waits.
//   If the receiver stalls, a finished query holds until that register frees.
//   Reset (rst, synchronous) clears the sequencer and result_valid; the point
//   store keeps its contents and a slot is undefined until loaded.
`default_nettype none

module euclidean_distance_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output      logic                                item_ready,
  input  wire logic                                op,
  input  wire logic [edt_pkg::IDX_W-1:0]           point_index,
  input  wire logic signed [edt_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [edt_pkg::COORD_W-1:0]  coord_y,
  input  wire logic [edt_pkg::IDX_W-1:0]           from_index,
  input  wire logic [edt_pkg::IDX_W-1:0]           to_index,
  output      logic                                result_valid,
  input  wire logic                                result_ready,
  output      logic [edt_pkg::DIST_W-1:0]          distance
);

  edt_pkg::state_t state;
  logic            done;

  logic [edt_pkg::IDX_W-1:0]          to_idx;
  logic [edt_pkg::IDX_W-1:0]          raddr;
  logic [edt_pkg::POINT_W-1:0]        rdata;
  logic [edt_pkg::POINT_W-1:0]        point_a;
  logic [edt_pkg::MAG_W-1:0]          dx;
  logic [edt_pkg::MAG_W-1:0]          dy;
  logic [edt_pkg::MAG_W-1:0]          mul_in;
  logic [2*edt_pkg::MAG_W-1:0]        square;
  logic [edt_pkg::SUM_W-1:0]          acc;
  logic [edt_pkg::SUM_W-1:0]          rad;
  logic [edt_pkg::REM_W-1:0]          rem;
  logic [edt_pkg::DIST_W-1:0]         root;
  logic [edt_pkg::CNT_W-1:0]          cnt;

  logic signed [edt_pkg::DIFF_W-1:0]  diff_x;
  logic signed [edt_pkg::DIFF_W-1:0]  diff_y;
  logic [edt_pkg::REM_W+1:0]          rem_shift;
  logic [edt_pkg::REM_W+1:0]          trial;
  logic                               take;
  logic                               accept;
  logic                               out_free;

  assign item_ready = (state == edt_pkg::S_IDLE) && !done;
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    raddr = to_idx;
    if (state == edt_pkg::S_IDLE) begin
      raddr = from_index;
    end
  end

  edt_ram #(
    .WIDTH (edt_pkg::POINT_W),
    .DEPTH (edt_pkg::POINTS)
  ) u_points (
    .clk   (clk),
    .we    (accept && (op == edt_pkg::OP_LOAD)),
    .waddr (point_index),
    .wdata ({coord_x, coord_y}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // point layout: x in the upper half, y in the lower half
  assign diff_x = edt_pkg::DIFF_W'(signed'(point_a[edt_pkg::POINT_W-1:edt_pkg::COORD_W]))
                - edt_pkg::DIFF_W'(signed'(rdata[edt_pkg::POINT_W-1:edt_pkg::COORD_W]));
  assign diff_y = edt_pkg::DIFF_W'(signed'(point_a[edt_pkg::COORD_W-1:0]))
                - edt_pkg::DIFF_W'(signed'(rdata[edt_pkg::COORD_W-1:0]));

  assign mul_in = (state == edt_pkg::S_SQ_X) ? dx : dy;
  assign square = mul_in * mul_in;

  assign rem_shift = {rem, rad[edt_pkg::SUM_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign take      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= edt_pkg::S_IDLE;
      done         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (done && out_free) begin
        result_valid <= 1'b1;
        distance     <= root;
        done         <= 1'b0;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        edt_pkg::S_IDLE: begin
          if (accept && (op == edt_pkg::OP_QUERY)) begin
            to_idx <= to_index;
            if (from_index == to_index) begin
              root <= '0;
              done <= 1'b1;
            end else begin
              state <= edt_pkg::S_READ_A;
            end
          end
        end
        edt_pkg::S_READ_A: begin
          point_a <= rdata;
          state   <= edt_pkg::S_READ_B;
        end
        edt_pkg::S_READ_B: begin
          state <= edt_pkg::S_DIFF;
        end
        edt_pkg::S_DIFF: begin
          dx    <= diff_x[edt_pkg::DIFF_W-1] ? edt_pkg::MAG_W'(-diff_x)
                                             : edt_pkg::MAG_W'(diff_x);
          dy    <= diff_y[edt_pkg::DIFF_W-1] ? edt_pkg::MAG_W'(-diff_y)
                                             : edt_pkg::MAG_W'(diff_y);
          state <= edt_pkg::S_SQ_X;
        end
        edt_pkg::S_SQ_X: begin
          acc   <= edt_pkg::SUM_W'(square);
          state <= edt_pkg::S_SQ_Y;
        end
        edt_pkg::S_SQ_Y: begin
          rad   <= acc + edt_pkg::SUM_W'(square);
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= edt_pkg::S_ROOT;
        end
        edt_pkg::S_ROOT: begin
          rad  <= rad << 2;
          rem  <= take ? edt_pkg::REM_W'(rem_shift - trial) : edt_pkg::REM_W'(rem_shift);
          root <= {root[edt_pkg::DIST_W-2:0], take};
          cnt  <= cnt + 1'b1;
          if (cnt == edt_pkg::CNT_W'(edt_pkg::ROOT_STEPS - 1)) begin
            done  <= 1'b1;
            state <= edt_pkg::S_IDLE;
          end
        end
        default: begin
          state <= edt_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/edt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module edt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
